[design/yuyv_to_rgb565_converter_defines.svh]
// Assertion macros for the YUYV to RGB565 converter.
`ifndef YUYV_TO_RGB565_CONVERTER_DEFINES_SVH
`define YUYV_TO_RGB565_CONVERTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define YUYV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("yuyv converter: same-cycle check failed");

// next-cycle implication, checked out of reset
`define YUYV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("yuyv converter: next-cycle check failed");

`endif

[design/yuyv_pkg.sv]
// Constants, types and color math for the YUYV to RGB565 converter.
`timescale 1ns / 1ps

package yuyv_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int COL_W     = $clog2(MAX_DIM / 2);
  localparam int ROW_W     = $clog2(MAX_DIM);
  localparam int REG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 8;
  localparam int RGB_W     = 16;
  localparam int ADDR_W    = 25;
  localparam int CMP_W     = ((ROW_W > REG_W) ? ROW_W : REG_W) + 1;
  localparam int PROD_W    = ((ROW_W + REG_W + 1) > ADDR_W) ? (ROW_W + REG_W + 1) : ADDR_W;
  localparam int CH_W      = 22;
  localparam int CH_BITS   = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE  = CFG_IDX_W'(2);

  localparam logic [REG_W-1:0] WIDTH_RST  = REG_W'(640);
  localparam logic [REG_W-1:0] HEIGHT_RST = REG_W'(480);
  localparam logic [REG_W-1:0] STRIDE_RST = REG_W'(640);

  localparam logic [PIX_W-1:0] LUMA_OFS = PIX_W'(16);

  typedef logic [PIX_W-1:0]        sample_t;
  typedef logic signed [CH_W-1:0]  ch_sum_t;
  typedef logic [CH_BITS-1:0]      ch_t;
  typedef logic [RGB_W-1:0]        rgb565_t;

  localparam ch_sum_t CHROMA_OFS = CH_W'(128);
  localparam ch_sum_t COEF_Y     = CH_W'(1192);
  localparam ch_sum_t COEF_RV    = CH_W'(1634);
  localparam ch_sum_t COEF_GV    = CH_W'(833);
  localparam ch_sum_t COEF_GU    = CH_W'(400);
  localparam ch_sum_t COEF_BU    = CH_W'(2066);
  localparam ch_sum_t CH_MAX     = CH_W'(262143);

  // 1192 * max(Y - 16, 0)
  function automatic ch_sum_t luma_term(sample_t raw);
    sample_t y;
    y = (raw >= LUMA_OFS) ? sample_t'(raw - LUMA_OFS) : '0;
    return $signed(CH_W'(y)) * COEF_Y;
  endfunction

  function automatic ch_sum_t chroma_term(sample_t raw);
    return $signed(CH_W'(raw)) - CHROMA_OFS;
  endfunction

  function automatic ch_t clamp_ch(ch_sum_t x);
    ch_t res;
    if (x < 0) begin
      res = '0;
    end else if (x > CH_MAX) begin
      res = CH_MAX[CH_BITS-1:0];
    end else begin
      res = x[CH_BITS-1:0];
    end
    return res;
  endfunction

  function automatic rgb565_t to_565(ch_sum_t yterm, ch_sum_t rv, ch_sum_t guv, ch_sum_t bu);
    ch_t r;
    ch_t g;
    ch_t b;
    r = clamp_ch(yterm + rv);
    g = clamp_ch(yterm - guv);
    b = clamp_ch(yterm + bu);
    return {r[CH_BITS-1 -: 5], g[CH_BITS-1 -: 6], b[CH_BITS-1 -: 5]};
  endfunction

endpackage

[design/yuyv_to_rgb565_converter.sv]
// YUYV to RGB565 converter top level: pixel pair conversion and frame addressing.
// Pipeline: an accepted input word goes to the input register, then to the result register.
// Throughput: one pixel pair per cycle unless out_stall_i holds the result; the color math
// and the row * stride multiply each fit between the input and result registers.
// Reset: async active low; clears pipeline valids, column/row counters and sets
// the geometry registers to 640 x 480, stride 640.
`timescale 1ns / 1ps
`include "yuyv_to_rgb565_converter_defines.svh"

module yuyv_to_rgb565_converter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [yuyv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [yuyv_pkg::REG_W-1:0]      cfg_data_i,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [yuyv_pkg::PIX_W-1:0]      luma_first_i,
  input  logic [yuyv_pkg::PIX_W-1:0]      chroma_blue_i,
  input  logic [yuyv_pkg::PIX_W-1:0]      luma_second_i,
  input  logic [yuyv_pkg::PIX_W-1:0]      chroma_red_i,
  // result words
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [yuyv_pkg::RGB_W-1:0]      pixel_first_o,
  output logic [yuyv_pkg::RGB_W-1:0]      pixel_second_o,
  output logic [yuyv_pkg::ADDR_W-1:0]     byte_address_o,
  output logic                            frame_end_o
);

  import yuyv_pkg::*;

  logic [REG_W-1:0] width_q, height_q, stride_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic             s1_valid_q;
  sample_t          s1_y1_q, s1_u_q, s1_y2_q, s1_v_q;
  logic [COL_W-1:0] s1_col_q;
  logic [ROW_W-1:0] s1_row_q;
  logic             s1_end_q;

  logic             out_valid_q;
  rgb565_t          pix1_q, pix2_q;
  logic [ADDR_W-1:0] addr_q;
  logic             end_q;

  logic             s2_adv, s1_adv, in_acc, cfg_acc;
  logic [CMP_W-1:0] pairs, rows;
  logic             last_col, last_row;

  ch_sum_t          yt1, yt2, u_c, v_c, rv, guv, bu;
  logic [PROD_W-1:0] addr_sum;

  // pipeline flow
  assign s2_adv     = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;
  assign in_acc     = in_valid_i && s1_adv;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc    = cfg_valid_i && cfg_ready_o;

  // frame geometry, clamped to 1..MAX_DIM/2 pairs and 1..MAX_DIM lines
  always_comb begin
    pairs = CMP_W'(width_q >> 1);
    if (pairs == '0) begin
      pairs = CMP_W'(1);
    end else if (pairs > CMP_W'(MAX_DIM / 2)) begin
      pairs = CMP_W'(MAX_DIM / 2);
    end
    rows = CMP_W'(height_q);
    if (rows == '0) begin
      rows = CMP_W'(1);
    end else if (rows > CMP_W'(MAX_DIM)) begin
      rows = CMP_W'(MAX_DIM);
    end
  end

  // >= so a counter past a shrunken limit still wraps
  assign last_col = CMP_W'(col_q) >= (pairs - CMP_W'(1));
  assign last_row = CMP_W'(row_q) >= (rows - CMP_W'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : ROW_W'(row_q + 1'b1);
      end else begin
        col_d = COL_W'(col_q + 1'b1);
      end
    end
  end

  // color math and address from the input register
  always_comb begin
    yt1 = luma_term(s1_y1_q);
    yt2 = luma_term(s1_y2_q);
    u_c = chroma_term(s1_u_q);
    v_c = chroma_term(s1_v_q);
    rv  = COEF_RV * v_c;
    guv = COEF_GV * v_c + COEF_GU * u_c;
    bu  = COEF_BU * u_c;
    addr_sum = PROD_W'(s1_row_q) * PROD_W'(stride_q) + PROD_W'({s1_col_q, 1'b0});
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      stride_q    <= STRIDE_RST;
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index_i)
          CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
          CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
          CFG_LINE_STRIDE:  stride_q <= cfg_data_i;
          default: ;
        endcase
      end
      col_q <= col_d;
      row_q <= row_d;
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_y1_q  <= luma_first_i;
      s1_u_q   <= chroma_blue_i;
      s1_y2_q  <= luma_second_i;
      s1_v_q   <= chroma_red_i;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
      s1_end_q <= last_col && last_row;
    end
    if (s2_adv && s1_valid_q) begin
      pix1_q <= to_565(yt1, rv, guv, bu);
      pix2_q <= to_565(yt2, rv, guv, bu);
      addr_q <= {addr_sum[ADDR_W-2:0], 1'b0};
      end_q  <= s1_end_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_first_o  = pix1_q;
  assign pixel_second_o = pix2_q;
  assign byte_address_o = addr_q;
  assign frame_end_o    = end_q;

  // last word of a frame sends both counters back to the origin
  `YUYV_ASSERT_NEXT(a_frame_wrap, in_acc && last_col && last_row, col_q == '0 && row_q == '0)
  // a full input stage behind a stalled result must hold off new words
  `YUYV_ASSERT_IMPL(a_backpressure, s1_valid_q && out_valid_q && out_stall_i, in_stall_o)
  // a result only appears after the input stage held a word
  `YUYV_ASSERT_IMPL(a_result_source, $rose(out_valid_q), $past(s1_valid_q))

endmodule
